// ===== design/m2mp_pkg.sv =====
// Shared constants for the 2x2 modular matrix power block.
`default_nettype none
package m2mp_pkg;
   localparam int ENTRY_WIDTH_DEF = 16;
   localparam int EXP_WIDTH_DEF   = 31;
   // Sequencer states
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_PREP = 3'd1;
   localparam logic [2:0] ST_MULT = 3'd2;
   localparam logic [2:0] ST_NEXT = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;
endpackage
`default_nettype wire

// ===== design/m2mp_mulmod.sv =====
// Bit-serial modular multiply-accumulate: result = (acc + a*b) mod m.
`default_nettype none
module m2mp_mulmod #(
   parameter int ENTRY_WIDTH = m2mp_pkg::ENTRY_WIDTH_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic [ENTRY_WIDTH-1:0] acc_init,
   input  wire logic [ENTRY_WIDTH-1:0] op_a,
   input  wire logic [ENTRY_WIDTH-1:0] op_b,
   input  wire logic [ENTRY_WIDTH-1:0] modulus,
   output logic                        done,
   output logic [ENTRY_WIDTH-1:0]      result
);
   localparam int CW = $clog2(ENTRY_WIDTH + 2);

   logic [ENTRY_WIDTH-1:0] a_ff, a_in;
   logic [ENTRY_WIDTH-1:0] b_ff, b_in;
   logic [ENTRY_WIDTH-1:0] c_ff, c_in;  // addend folded in on the last step
   logic [ENTRY_WIDTH-1:0] r_ff, r_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic                   last;
   logic [ENTRY_WIDTH+1:0] dbl, dsub, add, asub;
   logic [ENTRY_WIDTH:0]   dred;

   // Horner step over b from the MSB: r = 2r (+a), each reduced once;
   // the final step adds the accumulator input instead of doubling
   always_comb begin
      last = (cnt_ff == CW'(1));
      dbl  = last ? {2'b00, r_ff} : {1'b0, r_ff, 1'b0};
      dsub = dbl - {2'b00, modulus};
      dred = (dbl >= {2'b00, modulus}) ? dsub[ENTRY_WIDTH:0] : dbl[ENTRY_WIDTH:0];
      add  = {1'b0, dred} + (last ? {2'b00, c_ff} :
                             (b_ff[ENTRY_WIDTH-1] ? {2'b00, a_ff} : '0));
      asub = add - {2'b00, modulus};
      a_in = a_ff;
      b_in = b_ff;
      c_in = c_ff;
      r_in = r_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in    = op_a;
         b_in    = op_b;
         c_in    = acc_init;
         r_in    = '0;
         cnt_in  = CW'(ENTRY_WIDTH + 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         r_in   = (add >= {2'b00, modulus}) ? asub[ENTRY_WIDTH-1:0] : add[ENTRY_WIDTH-1:0];
         b_in   = {b_ff[ENTRY_WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      c_ff   <= c_in;
      r_ff   <= r_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done   = done_ff;
   assign result = r_ff;

   assert property (@(posedge clock) disable iff (reset) done_ff |-> !busy_ff)
      else $error("mulmod done while busy");
   assert property (@(posedge clock) disable iff (reset) start |=> busy_ff)
      else $error("mulmod did not start");
   assert property (@(posedge clock) disable iff (reset)
      busy_ff && modulus != '0 |-> r_ff < modulus)
      else $error("mulmod residue out of range");
endmodule
`default_nettype wire

// ===== design/matrix2x2_modular_power.sv =====
// Top level of the 2x2 modular matrix power block.
// Usage:
//  req_ carries one job: matrix, exponent and modulus. rsp_ returns M^n mod m.
//  A job is accepted when req_tvalid and req_tready are both high; req_tready
//  is high only while the block is idle, so one job is in flight at a time.
//  Exponent 0 answers the identity straight from the DONE state. Otherwise each
//  of the EXP_WIDTH exponent bits runs a squaring and, for a set bit, a
//  multiply by M. A product takes eight serial multiply-accumulates on the
//  single bit-serial mulmod unit, then a commit in the NEXT state. The four
//  entries are first reduced (one pass each). All work is serialised on that
//  one mulmod unit; the next job is taken once the result leaves.
//  The result sits in an output register until rsp_tready; while it waits the
//  block takes no new job. Reset drops any job in flight and empties the
//  output register. A zero modulus with a nonzero exponent gives all-zero
//  entries.
`default_nettype none
module matrix2x2_modular_power #(
   parameter int ENTRY_WIDTH = m2mp_pkg::ENTRY_WIDTH_DEF,
   parameter int EXP_WIDTH   = m2mp_pkg::EXP_WIDTH_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic      req_tready,
   // m00, m01, m10, m11, exponent, modulus, zero fill
   input  wire logic [((5*ENTRY_WIDTH+EXP_WIDTH+7)/8)*8-1:0] req_tdata,
   output logic      rsp_tvalid,
   input  wire logic rsp_tready,
   // r00, r01, r10, r11
   output logic [((4*ENTRY_WIDTH+7)/8)*8-1:0] rsp_tdata
);
   localparam int EW = ENTRY_WIDTH;
   localparam int OW = ((4*ENTRY_WIDTH+7)/8)*8;
   localparam int BW = (EXP_WIDTH > 1) ? $clog2(EXP_WIDTH) : 1;

   logic [2:0]       st_ff, st_in;
   logic [EW-1:0]    base_ff [4];
   logic [EW-1:0]    base_in [4];
   logic [EW-1:0]    acc_ff [4];
   logic [EW-1:0]    acc_in [4];
   logic [EW-1:0]    nxt_ff [4];
   logic [EW-1:0]    nxt_in [4];
   logic [EXP_WIDTH-1:0] exp_ff, exp_in;
   logic [EW-1:0]    mod_ff, mod_in;
   logic [BW-1:0]    bit_ff, bit_in;
   logic             mulb_ff, mulb_in;  // second product of this bit
   logic [1:0]       ent_ff, ent_in;    // entry index i*2+j
   logic             term_ff, term_in;  // which of the two terms
   logic             go_ff, go_in;
   logic             ovld_ff, ovld_in;
   logic [OW-1:0]    odat_ff, odat_in;
   logic [EW-1:0]    mm_init, mm_a, mm_b, mm_res;
   logic             mm_done;
   logic [EW-1:0]    one_red;
   logic [EW-1:0]    rhs [4];

   m2mp_mulmod #(.ENTRY_WIDTH(EW)) u_mulmod (
      .clock(clock), .reset(reset), .start(go_ff), .acc_init(mm_init),
      .op_a(mm_a), .op_b(mm_b), .modulus(mod_ff), .done(mm_done), .result(mm_res));

   assign one_red = (mod_ff == EW'(1) || mod_ff == '0) ? '0 : EW'(1);

   // Operand selection: PREP reduces entries as 1*x, MULT forms acc*rhs
   always_comb begin
      for (int k = 0; k < 4; k++) rhs[k] = mulb_ff ? base_ff[k] : acc_ff[k];
      if (st_ff == m2mp_pkg::ST_PREP) begin
         mm_init = '0;
         mm_a    = one_red;
         mm_b    = base_ff[ent_ff];
      end else begin
         mm_init = term_ff ? nxt_ff[ent_ff] : '0;
         mm_a    = acc_ff[{ent_ff[1], term_ff}];
         mm_b    = rhs[{term_ff, ent_ff[0]}];
      end
   end

   always_comb begin
      st_in = st_ff; base_in = base_ff; acc_in = acc_ff; nxt_in = nxt_ff;
      exp_in = exp_ff; mod_in = mod_ff; bit_in = bit_ff; mulb_in = mulb_ff;
      ent_in = ent_ff; term_in = term_ff; go_in = 1'b0;
      ovld_in = ovld_ff; odat_in = odat_ff;
      if (ovld_ff && rsp_tready) ovld_in = 1'b0;
      unique case (st_ff)
         m2mp_pkg::ST_IDLE: begin
            if (req_tvalid && !ovld_ff) begin
               for (int k = 0; k < 4; k++) base_in[k] = req_tdata[k*EW +: EW];
               exp_in = req_tdata[4*EW +: EXP_WIDTH];
               mod_in = req_tdata[4*EW+EXP_WIDTH +: EW];
               bit_in = BW'(EXP_WIDTH - 1);
               ent_in = '0; term_in = 1'b0; mulb_in = 1'b0;
               if (req_tdata[4*EW +: EXP_WIDTH] == '0) begin
                  st_in = m2mp_pkg::ST_DONE;
                  acc_in[0] = EW'(1); acc_in[1] = '0; acc_in[2] = '0; acc_in[3] = EW'(1);
               end else begin
                  st_in = m2mp_pkg::ST_PREP;
                  go_in = 1'b1;
               end
            end
         end
         m2mp_pkg::ST_PREP: begin
            if (mm_done) begin
               base_in[ent_ff] = mm_res;
               ent_in = ent_ff + 2'd1;
               go_in  = 1'b1;
               if (ent_ff == 2'd3) begin
                  acc_in[0] = one_red; acc_in[1] = '0; acc_in[2] = '0; acc_in[3] = one_red;
                  st_in = m2mp_pkg::ST_MULT;
               end
            end
         end
         m2mp_pkg::ST_MULT: begin
            if (mm_done) begin
               nxt_in[ent_ff] = mm_res;
               term_in = ~term_ff;
               if (!term_ff) go_in = 1'b1;
               else if (ent_ff != 2'd3) begin
                  ent_in = ent_ff + 2'd1;
                  go_in  = 1'b1;
               end else st_in = m2mp_pkg::ST_NEXT;
            end
         end
         m2mp_pkg::ST_NEXT: begin
            acc_in = nxt_ff;
            ent_in = '0;
            if (!mulb_ff && exp_ff[bit_ff]) begin
               mulb_in = 1'b1; go_in = 1'b1; st_in = m2mp_pkg::ST_MULT;
            end else if (bit_ff == '0) begin
               st_in = m2mp_pkg::ST_DONE;
            end else begin
               mulb_in = 1'b0; bit_in = bit_ff - 1'b1; go_in = 1'b1;
               st_in = m2mp_pkg::ST_MULT;
            end
         end
         m2mp_pkg::ST_DONE: begin
            if (!ovld_ff) begin
               odat_in = '0;
               for (int k = 0; k < 4; k++) odat_in[k*EW +: EW] = acc_ff[k];
               ovld_in = 1'b1;
               st_in = m2mp_pkg::ST_IDLE;
            end
         end
         default: st_in = m2mp_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      base_ff <= base_in; acc_ff <= acc_in; nxt_ff <= nxt_in;
      exp_ff <= exp_in; mod_ff <= mod_in; bit_ff <= bit_in;
      mulb_ff <= mulb_in; ent_ff <= ent_in; term_ff <= term_in;
      odat_ff <= odat_in;
      if (reset) begin
         st_ff <= m2mp_pkg::ST_IDLE; go_ff <= 1'b0; ovld_ff <= 1'b0;
      end else begin
         st_ff <= st_in; go_ff <= go_in; ovld_ff <= ovld_in;
      end
   end

   assign req_tready = (st_ff == m2mp_pkg::ST_IDLE) && !ovld_ff;
   assign rsp_tvalid = ovld_ff;
   assign rsp_tdata  = odat_ff;

   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> st_ff != m2mp_pkg::ST_IDLE)
      else $error("accepted transaction not started");
   assert property (@(posedge clock) disable iff (reset)
      ovld_ff && !rsp_tready |=> ovld_ff && $stable(odat_ff))
      else $error("result lost under stall");
   assert property (@(posedge clock) disable iff (reset)
      go_ff |-> st_ff == m2mp_pkg::ST_PREP || st_ff == m2mp_pkg::ST_MULT)
      else $error("mulmod started outside a product");
endmodule
`default_nettype wire

// ===== test/m2mp_checker.sv =====
// Checker for the 2x2 modular matrix power block: predicts M^n mod m and compares results.
`default_nettype none
module m2mp_checker #(
   parameter int ENTRY_WIDTH = 16,
   parameter int EXP_WIDTH   = 31,
   parameter int REQ_W       = ((5*ENTRY_WIDTH+EXP_WIDTH+7)/8)*8,
   parameter int RSP_W       = ((4*ENTRY_WIDTH+7)/8)*8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   input  wire logic             req_tready,
   input  wire logic [REQ_W-1:0] req_tdata,
   input  wire logic             rsp_tvalid,
   input  wire logic             rsp_tready,
   input  wire logic [RSP_W-1:0] rsp_tdata,
   output int                    fail_count,
   output int                    pending_count,
   output int                    result_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic [4*ENTRY_WIDTH-1:0] quad_type;
   typedef logic [63:0] word_type;

   quad_type power_queue[$];

   function automatic word_type reduce(word_type x, word_type m);
      if (m == 0) return 0;
      return x % m;
   endfunction

   // Multiply two 2x2 matrices (row major a00,a01,a10,a11), reducing each step
   function automatic void mat_mul(input word_type a[4], input word_type b[4],
                                   input word_type m, output word_type r[4]);
      for (int i = 0; i < 2; i++)
         for (int j = 0; j < 2; j++)
            r[2*i+j] = reduce(reduce(a[2*i]*b[j], m) + reduce(a[2*i+1]*b[2+j], m), m);
   endfunction

   // Binary exponentiation, exponent scanned from the top bit
   function automatic quad_type matrix_power(logic [REQ_W-1:0] d);
      word_type m, n;
      word_type base[4];
      word_type acc[4];
      word_type tmp[4];
      quad_type res;
      m = d[4*ENTRY_WIDTH+EXP_WIDTH +: ENTRY_WIDTH];
      n = d[4*ENTRY_WIDTH +: EXP_WIDTH];
      if (n == 0) return {ENTRY_WIDTH'(1), ENTRY_WIDTH'(0), ENTRY_WIDTH'(0), ENTRY_WIDTH'(1)};
      for (int k = 0; k < 4; k++) base[k] = reduce(d[k*ENTRY_WIDTH +: ENTRY_WIDTH], m);
      acc[0] = reduce(1, m); acc[1] = 0; acc[2] = 0; acc[3] = reduce(1, m);
      for (int b = EXP_WIDTH-1; b >= 0; b--) begin
         mat_mul(acc, acc, m, tmp);
         acc = tmp;
         if (n[b]) begin
            mat_mul(acc, base, m, tmp);
            acc = tmp;
         end
      end
      for (int k = 0; k < 4; k++) res[k*ENTRY_WIDTH +: ENTRY_WIDTH] = acc[k][ENTRY_WIDTH-1:0];
      return res;
   endfunction

   // Predict on each accepted request, compare on each accepted response
   always @(posedge clock) begin
      quad_type want;
      int errs;
      errs = 0;
      if (reset) begin
         power_queue.delete();
         fail_count <= 0;
         result_count <= 0;
         pending_count <= 0;
      end else begin
         if (req_tvalid && req_tready) power_queue.push_back(matrix_power(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            result_count <= result_count + 1;
            if (power_queue.size() == 0) begin
               $error("unexpected result transaction %h", rsp_tdata);
               errs = errs + 1;
            end else begin
               want = power_queue.pop_front();
               for (int k = 0; k < 4; k++)
                  if (rsp_tdata[k*ENTRY_WIDTH +: ENTRY_WIDTH] !==
                      want[k*ENTRY_WIDTH +: ENTRY_WIDTH]) begin
                     $error("field r%0d%0d: expected %0d, got %0d", k/2, k%2,
                            want[k*ENTRY_WIDTH +: ENTRY_WIDTH],
                            rsp_tdata[k*ENTRY_WIDTH +: ENTRY_WIDTH]);
                     errs = errs + 1;
                  end
            end
         end
         fail_count <= fail_count + errs;
         pending_count <= power_queue.size();
      end
   end
endmodule
`default_nettype wire

// ===== test/tb_matrix2x2_modular_power.sv =====
// Testbench top for the 2x2 modular matrix power block: stimulus, idling and verdict.
`default_nettype none
module tb_matrix2x2_modular_power;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int EW    = m2mp_pkg::ENTRY_WIDTH_DEF;
   localparam int XW    = m2mp_pkg::EXP_WIDTH_DEF;
   localparam int REQ_W = ((5*EW+XW+7)/8)*8;
   localparam int RSP_W = ((4*EW+7)/8)*8;
   localparam int RANDOM_JOBS = 280;
   localparam longint CYCLE_LIMIT = 64'd20_000_000;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0; // m00, m01, m10, m11, exponent, modulus, zero fill
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [RSP_W-1:0] rsp_tdata;     // r00, r01, r10, r11
   int fail_count, pending_count, result_count;
   longint cycles = 0;
   bit quiet_phase = 0;
   int jobs_sent = 0;

   matrix2x2_modular_power uut (.*);

   m2mp_checker #(.ENTRY_WIDTH(EW), .EXP_WIDTH(XW)) u_checker (.*);

   initial forever #5 clock = ~clock;

   // Bound the run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Stall the response side in random bursts
   initial begin
      int gap;
      forever begin
         @(posedge clock);
         if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 9);
            rsp_tready <= 0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1;
      end
   end

   // Drive one transaction; valid stays high into the next one unless a gap follows
   task automatic send_job(int unsigned a, b, c, d, n, m);
      int gap;
      if (!quiet_phase && $urandom_range(0, 2) == 0) begin
         gap = $urandom_range(1, 9);
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tdata <= REQ_W'({EW'(m), XW'(n), EW'(d), EW'(c), EW'(b), EW'(a)});
      req_tvalid <= 1;
      do @(posedge clock); while (!req_tready);
      jobs_sent++;
   endtask

   function automatic int unsigned rand_entry();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 3);
         1: return 'hFFFF - $urandom_range(0, 3);
         default: return $urandom & 'hFFFF;
      endcase
   endfunction

   initial begin
      int unsigned m;
      int unsigned n;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // Directed: zero exponent, modulus one, extremes, entries above the modulus
      send_job(5, 6, 7, 8, 0, 1);
      send_job('hFFFF, 'hFFFF, 'hFFFF, 'hFFFF, 0, 'hFFFF);
      send_job(1, 1, 1, 0, 10, 1);
      send_job(1, 1, 1, 0, 1, 'hFFFF);
      send_job(1, 1, 1, 0, 90, 'hFFFF);
      send_job('hFFFF, 'hFFFF, 'hFFFF, 'hFFFF, 'h7FFFFFFF, 'hFFFF);
      send_job('hFFFE, 'hFFFD, 'h1234, 'hFFFF, 'h7FFFFFFF, 'hFFFF);
      send_job('hFFFF, 'h8000, 'h7FFF, 'h0001, 'h40000000, 'hFFFB);
      send_job(0, 0, 0, 0, 5, 7);
      send_job(100, 200, 300, 400, 3, 7);
      send_job('hAAAA, 'h5555, 'hAAAA, 'h5555, 'h55555555, 'h8000);
      send_job(3, 4, 5, 6, 'h2AAAAAAA, 2);
      send_job(1, 2, 3, 4, 2, 0);
      send_job(1, 0, 0, 1, 'h7FFFFFFF, 'hFFF1);
      // Random: mostly entries below the modulus, some above
      for (int i = 0; i < RANDOM_JOBS; i++) begin
         if (i > RANDOM_JOBS - 30) quiet_phase = 1;
         case ($urandom_range(0, 3))
            0: m = $urandom_range(1, 16);
            1: m = 'hFFFF - $urandom_range(0, 15);
            default: m = $urandom_range(1, 'hFFFF);
         endcase
         case ($urandom_range(0, 4))
            0: n = $urandom_range(0, 8);
            1: n = 'h7FFFFFFF - $urandom_range(0, 255);
            default: n = $urandom & 'h7FFFFFFF;
         endcase
         if ($urandom_range(0, 3) == 0)
            send_job(rand_entry(), rand_entry(), rand_entry(), rand_entry(), n, m);
         else
            send_job($urandom % m, $urandom % m, $urandom % m, $urandom % m, n, m);
      end
      req_tvalid <= 0;
      quiet_phase = 1;
      while (result_count != jobs_sent || pending_count != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      $display("Ran %0d jobs (%0d results): identity, modulus 0/1/max, full exponents,",
               jobs_sent, result_count);
      $display("oversized entries, random matrices with idle and stall bursts.");
      if (fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end
endmodule
`default_nettype wire
